>>> rtl/core/acdt_pkg.sv
// Shared types and constants for the adaptive change debounce trigger.
// Used by the top level and the duration history; has no dependencies of its own.
package acdt_pkg;

	typedef enum logic [1:0] {
		OP_QUERY  = 2'd0,
		OP_START  = 2'd1,
		OP_FINISH = 2'd2,
		OP_CLEAR  = 2'd3
	} acdt_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_APPLY,
		ST_DUR,
		ST_SUM,
		ST_MUL,
		ST_GRACE,
		ST_SLAST,
		ST_SOLD,
		ST_CMPL,
		ST_CMPO,
		ST_DONE
	} acdt_state_t;

	// Configuration register indexes
	localparam logic [1:0] REG_MAX_WAIT  = 2'd0;
	localparam logic [1:0] REG_SLOW_THR  = 2'd1;
	localparam logic [1:0] REG_GRACE     = 2'd2;

	localparam logic [15:0] MAX_WAIT_RST = 16'd3000;
	localparam logic [15:0] SLOW_THR_RST = 16'd1500;
	localparam logic [15:0] GRACE_RST    = 16'd250;

	localparam int DUR_W = 32;

	// Control from the sequencer to the duration history
	typedef struct packed {
		logic push;
		logic clear;
	} acdt_hist_ctrl_t;

endpackage

>>> rtl/core/adaptive_change_debounce_trigger_top.sv
// Top level of the adaptive change debounce trigger: sequencer and state.
// Uses acdt_pkg, acdt_alu (shared add/compare) and acdt_hist (duration ring).
// Sequence: accept, apply, record the duration (a finish after a start only),
//   sum the history, multiply, grace decision, then for a query with a
//   fingerprint the since-last, since-oldest and two compare steps, then done.
// Throughput: one item at a time; the history sum runs through the shared adder,
//   one entry per cycle. A result waiting at the output holds the sequencer in
//   its done state, so the next item is not accepted until it is taken. Reset
//   restores register defaults and clears state at once; the duration ring needs no clearing pass.
module adaptive_change_debounce_trigger_top #(
	parameter int HISTORY_DEPTH = 10,
	parameter int TIME_BITS     = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [63:0] fingerprint,
	input  logic        fingerprint_present,
	input  logic [47:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        generate_res,
	output logic [15:0] grace_in_use_ms,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	localparam int HW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CW    = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W = acdt_pkg::DUR_W + CW;
	localparam int PW    = 17 + CW;
	localparam int AW0   = (TIME_BITS > SUM_W) ? TIME_BITS : SUM_W;
	localparam int AW    = (AW0 > PW) ? AW0 : PW;
	localparam logic [TIME_BITS-1:0] DUR_MAX = TIME_BITS'(33'h0_FFFF_FFFF);

	acdt_pkg::acdt_state_t state_q, state_d;

	// configuration
	logic [15:0] max_wait_q, slow_thr_q, grace_ms_q;

	// latched item
	acdt_pkg::acdt_op_t     op_q;
	logic [63:0]            fp_q;
	logic                   pres_q;
	logic [TIME_BITS-1:0]   now_q;
	logic [63:0]            now_ext;

	// debounce state
	logic [63:0]          last_digest_q;
	logic                 last_digest_valid_q;
	logic [TIME_BITS-1:0] last_change_q, oldest_change_q, job_start_q;
	logic                 pending_q;

	// working registers
	logic [CW-1:0]        idx_q;
	logic                 rd_pend_s1;
	logic [SUM_W-1:0]     acc_q;
	logic [PW-1:0]        prod_q;
	logic [15:0]          grace_q;
	logic [TIME_BITS-1:0] since_last_q, since_old_q;
	logic                 ge_q, gen_q;

	// output register
	logic        out_valid_q, out_gen_q;
	logic [15:0] out_grace_q;

	// shared unit and history
	logic [AW-1:0] alu_a, alu_b, alu_res;
	logic          alu_sub, alu_carry;
	acdt_pkg::acdt_hist_ctrl_t hist_ctrl;
	logic [acdt_pkg::DUR_W-1:0] dur_val, rd_data;
	logic [CW-1:0] hist_count;
	logic          issue, load_out, in_xfer, changed;
	logic [TIME_BITS-1:0] diff_t;
	logic [PW-1:0] prod_d;

	assign now_ext  = {16'd0, now_ms};
	assign in_xfer  = in_valid && !in_stall;
	assign issue    = (state_q == acdt_pkg::ST_SUM) && (idx_q < hist_count);
	assign load_out = (state_q == acdt_pkg::ST_DONE) && (!out_valid_q || !out_stall);
	assign changed  = !last_digest_valid_q || (last_digest_q != fp_q);
	assign diff_t   = alu_carry ? alu_res[TIME_BITS-1:0] : '0;
	assign dur_val  = (diff_t > DUR_MAX) ? DUR_MAX[acdt_pkg::DUR_W-1:0]
	                                     : diff_t[acdt_pkg::DUR_W-1:0];
	assign prod_d   = PW'({1'b0, slow_thr_q} + 17'd1) * PW'(hist_count);

	acdt_alu #(.W(AW)) u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.sub   (alu_sub),
		.res   (alu_res),
		.carry (alu_carry)
	);

	acdt_hist #(.DEPTH(HISTORY_DEPTH), .HW(HW), .CW(CW)) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (hist_ctrl),
		.wr_data (dur_val),
		.rd_addr (idx_q[HW-1:0]),
		.rd_data (rd_data),
		.count   (hist_count)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			acdt_pkg::ST_IDLE: begin
				if (in_valid) state_d = acdt_pkg::ST_APPLY;
			end
			acdt_pkg::ST_APPLY: begin
				if (op_q == acdt_pkg::OP_FINISH && job_start_q != '0) begin
					state_d = acdt_pkg::ST_DUR;
				end else begin
					state_d = acdt_pkg::ST_SUM;
				end
			end
			acdt_pkg::ST_DUR: state_d = acdt_pkg::ST_SUM;
			acdt_pkg::ST_SUM: begin
				if (!issue && !rd_pend_s1) state_d = acdt_pkg::ST_MUL;
			end
			acdt_pkg::ST_MUL: state_d = acdt_pkg::ST_GRACE;
			acdt_pkg::ST_GRACE: begin
				if (op_q == acdt_pkg::OP_QUERY && pres_q) begin
					state_d = acdt_pkg::ST_SLAST;
				end else begin
					state_d = acdt_pkg::ST_DONE;
				end
			end
			acdt_pkg::ST_SLAST: state_d = acdt_pkg::ST_SOLD;
			acdt_pkg::ST_SOLD:  state_d = acdt_pkg::ST_CMPL;
			acdt_pkg::ST_CMPL:  state_d = acdt_pkg::ST_CMPO;
			acdt_pkg::ST_CMPO:  state_d = acdt_pkg::ST_DONE;
			acdt_pkg::ST_DONE: begin
				if (load_out) state_d = acdt_pkg::ST_IDLE;
			end
			default: state_d = acdt_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: operand selection and history control
	always_comb begin
		alu_a           = '0;
		alu_b           = '0;
		alu_sub         = 1'b1;
		hist_ctrl.push  = 1'b0;
		hist_ctrl.clear = 1'b0;
		in_stall        = 1'b1;
		case (state_q)
			acdt_pkg::ST_IDLE: in_stall = 1'b0;
			acdt_pkg::ST_APPLY: hist_ctrl.clear = (op_q == acdt_pkg::OP_CLEAR);
			acdt_pkg::ST_DUR: begin
				alu_a          = AW'(now_q);
				alu_b          = AW'(job_start_q);
				hist_ctrl.push = 1'b1;
			end
			acdt_pkg::ST_SUM: begin
				alu_a   = AW'(acc_q);
				alu_b   = AW'(rd_data);
				alu_sub = 1'b0;
			end
			acdt_pkg::ST_GRACE: begin
				alu_a = AW'(acc_q);
				alu_b = AW'(prod_q);
			end
			acdt_pkg::ST_SLAST: begin
				alu_a = AW'(now_q);
				alu_b = AW'(last_change_q);
			end
			acdt_pkg::ST_SOLD: begin
				alu_a = AW'(now_q);
				alu_b = AW'(oldest_change_q);
			end
			acdt_pkg::ST_CMPL: begin
				alu_a = AW'(since_last_q);
				alu_b = AW'(grace_q);
			end
			acdt_pkg::ST_CMPO: begin
				alu_a = AW'(since_old_q);
				alu_b = AW'(max_wait_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= acdt_pkg::ST_IDLE;
			max_wait_q <= acdt_pkg::MAX_WAIT_RST;
			slow_thr_q <= acdt_pkg::SLOW_THR_RST;
			grace_ms_q <= acdt_pkg::GRACE_RST;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					acdt_pkg::REG_MAX_WAIT: max_wait_q <= cfg_wdata;
					acdt_pkg::REG_SLOW_THR: slow_thr_q <= cfg_wdata;
					acdt_pkg::REG_GRACE:    grace_ms_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	// debounce state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_digest_q       <= '0;
			last_digest_valid_q <= 1'b0;
			last_change_q       <= '0;
			oldest_change_q     <= '0;
			pending_q           <= 1'b1;
			job_start_q         <= '0;
		end else if (state_q == acdt_pkg::ST_APPLY) begin
			case (op_q)
				acdt_pkg::OP_QUERY: begin
					if (pres_q && changed) begin
						last_digest_q       <= fp_q;
						last_digest_valid_q <= 1'b1;
						last_change_q       <= now_q;
						if (!pending_q) oldest_change_q <= now_q;
						pending_q           <= 1'b1;
					end
				end
				acdt_pkg::OP_START: begin
					job_start_q <= now_q;
					pending_q   <= 1'b0;
				end
				acdt_pkg::OP_FINISH: ;
				acdt_pkg::OP_CLEAR: begin
					last_digest_q       <= '0;
					last_digest_valid_q <= 1'b0;
					last_change_q       <= '0;
					oldest_change_q     <= '0;
					pending_q           <= 1'b1;
					job_start_q         <= '0;
				end
				default: ;
			endcase
		end else if (state_q == acdt_pkg::ST_DUR) begin
			job_start_q <= '0;
		end
	end

	// sequencing counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= issue;
			if (state_q == acdt_pkg::ST_APPLY) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	// item latch and working datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q   <= acdt_pkg::acdt_op_t'(opcode);
			fp_q   <= fingerprint;
			pres_q <= fingerprint_present;
			now_q  <= now_ext[TIME_BITS-1:0];
		end
		case (state_q)
			acdt_pkg::ST_APPLY: begin
				acc_q <= '0;
				gen_q <= 1'b0;
			end
			acdt_pkg::ST_SUM: begin
				// accumulate the entry read in the previous cycle
				if (rd_pend_s1) acc_q <= alu_res[SUM_W-1:0];
			end
			acdt_pkg::ST_MUL: prod_q <= prod_d;
			acdt_pkg::ST_GRACE: begin
				// floor(sum / n) > thr  is  sum >= (thr + 1) * n
				grace_q <= (alu_carry && hist_count != '0) ? grace_ms_q : 16'd0;
			end
			acdt_pkg::ST_SLAST: since_last_q <= diff_t;
			acdt_pkg::ST_SOLD: begin
				since_old_q <= (oldest_change_q != '0) ? diff_t : since_last_q;
			end
			acdt_pkg::ST_CMPL: ge_q <= alu_carry;
			acdt_pkg::ST_CMPO: gen_q <= pending_q && (ge_q || alu_carry);
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_gen_q   <= gen_q;
			out_grace_q <= grace_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign generate_res    = out_gen_q;
	assign grace_in_use_ms = out_grace_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == acdt_pkg::ST_APPLY)
		else $error("accepted item did not start the sequencer");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hist_count <= CW'(HISTORY_DEPTH))
		else $error("history count beyond depth");

	a_read_in_sum: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> state_q == acdt_pkg::ST_SUM)
		else $error("history read left the summing phase");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid && state_q == acdt_pkg::ST_IDLE)
		else $error("finished result not presented");

endmodule

>>> rtl/core/acdt_alu.sv
// Shared add/subtract unit of the debounce trigger.
// Subtraction returns carry high when a >= b. Depends on nothing.
module acdt_alu #(
	parameter int W = 48
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] res,
	output logic         carry
);

	logic [W-1:0] b_op;

	assign b_op = sub ? ~b : b;
	assign {carry, res} = {1'b0, a} + {1'b0, b_op} + {{W{1'b0}}, sub};

endmodule

>>> rtl/core/acdt_hist.sv
// Ring of recent job durations with fill count and write head.
// Uses acdt_pkg for the control struct and duration width; read data is registered.
module acdt_hist #(
	parameter int DEPTH = 10,
	parameter int HW    = 4,
	parameter int CW    = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  acdt_pkg::acdt_hist_ctrl_t ctrl,
	input  logic [acdt_pkg::DUR_W-1:0] wr_data,
	input  logic [HW-1:0]            rd_addr,
	output logic [acdt_pkg::DUR_W-1:0] rd_data,
	output logic [CW-1:0]            count
);

	logic [acdt_pkg::DUR_W-1:0] mem [DEPTH];
	logic [HW-1:0] head_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[head_q] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (ctrl.clear) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (ctrl.push) begin
			// wrap the head at the ring depth
			if (head_q == HW'(DEPTH - 1)) begin
				head_q <= '0;
			end else begin
				head_q <= head_q + HW'(1);
			end
			if (count_q != CW'(DEPTH)) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	assign count = count_q;

endmodule
